@@ sv/hpp_pkg.sv @@
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared types and constants of the haptic packet pacer.
// ----------------------------------------------------------------------------
package hpp_pkg;

	localparam int TIME_W = 48;

	// input item kinds
	localparam logic [1:0] MODE_APPLY = 2'd0;
	localparam logic [1:0] MODE_STOP  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// result packet kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_RENDER  = 2'd1;
	localparam logic [1:0] KIND_SILENCE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_GAIN_TENTHS = 2'd0;
	localparam logic [1:0] REG_INTERVAL    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT     = 2'd2;

	// trailing packets kept after the synth goes silent
	localparam logic [1:0] TAIL_PACKETS = 2'd2;

	// reset values
	localparam logic [10:0] GAIN_Q8_RST  = 11'd256;
	localparam logic [15:0] INTERVAL_RST = 16'd10000;
	localparam logic [23:0] TIMEOUT_RST  = 24'd500000;

	// reciprocal of ten for the gain conversion, exact below 2^16
	localparam logic [15:0] RECIP_TEN = 16'd52429;
	localparam int          RECIP_SH  = 19;

	typedef struct packed {
		logic [10:0] gain_q8;
		logic [15:0] interval_us;
		logic [23:0] timeout_us;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              rumble_silent;
		logic              link_up;
		logic [TIME_W-1:0] now_us;
	} item_t;

	typedef struct packed {
		logic [1:0]  packet_kind;
		logic [10:0] gain_q8;
		logic        synth_silent_now;
		logic        watchdog_fired;
		logic        transport_on;
	} result_t;

endpackage

@@ sv/hpp_cfg.sv @@
// ----------------------------------------------------------------------------
// hpp_cfg
// Configuration registers; gain tenths are converted to Q8 on write.
// ----------------------------------------------------------------------------
module hpp_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data,
	output hpp_pkg::cfg_t cfg
);
	import hpp_pkg::*;

	logic [13:0] gain_num;
	logic [29:0] gain_prod;
	logic [10:0] gain_q8_q;
	logic [15:0] interval_q;
	logic [23:0] timeout_q;

	// (t*256+5)/10 through a reciprocal multiply
	assign gain_num  = {cfg_data[5:0], 8'd0} + 14'd5;
	assign gain_prod = 30'(gain_num) * 30'(RECIP_TEN);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q8_q  <= GAIN_Q8_RST;
			interval_q <= INTERVAL_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_TENTHS: gain_q8_q  <= gain_prod[RECIP_SH +: 11];
				REG_INTERVAL:    interval_q <= cfg_data[15:0];
				REG_TIMEOUT:     timeout_q  <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign cfg.gain_q8     = gain_q8_q;
	assign cfg.interval_us = interval_q;
	assign cfg.timeout_us  = timeout_q;

endmodule

@@ sv/hpp_core.sv @@
// ----------------------------------------------------------------------------
// hpp_core
// Pacer state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
module hpp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  hpp_pkg::item_t   item,
	input  hpp_pkg::cfg_t    cfg,
	output hpp_pkg::result_t result
);
	import hpp_pkg::*;

	logic              silent_q, silent_n;
	logic              active_q, active_n;
	logic [TIME_W-1:0] deadline_q, deadline_n;
	logic [TIME_W-1:0] last_cmd_q, last_cmd_n;
	logic [1:0]        tail_q, tail_n;
	logic              link_was_q, link_was_n;

	logic [TIME_W-1:0] since_cmd;
	logic [TIME_W-1:0] past_deadline;
	logic [TIME_W-1:0] interval_w;
	logic              wd_expired;
	logic              due;
	logic              late;
	logic [1:0]        kind;
	logic              fired;

	// time differences, modulo 2^48
	assign interval_w    = TIME_W'(cfg.interval_us);
	assign since_cmd     = item.now_us - last_cmd_q;
	assign past_deadline = item.now_us - deadline_q;
	assign wd_expired    = since_cmd >= TIME_W'(cfg.timeout_us);
	assign due           = (deadline_q == '0) || (item.now_us >= deadline_q);
	assign late          = (deadline_q == '0) || (past_deadline > interval_w);

	// next state for the item at hand
	always_comb begin
		silent_n   = silent_q;
		active_n   = active_q;
		deadline_n = deadline_q;
		last_cmd_n = last_cmd_q;
		tail_n     = tail_q;
		link_was_n = link_was_q;
		kind       = KIND_NONE;
		fired      = 1'b0;
		case (item.mode)
			MODE_APPLY: begin
				silent_n   = item.rumble_silent;
				last_cmd_n = item.now_us;
				if (!active_q) deadline_n = '0;
				active_n   = 1'b1;
				tail_n     = item.rumble_silent ? TAIL_PACKETS : 2'd0;
			end
			MODE_STOP: begin
				silent_n   = 1'b1;
				active_n   = 1'b0;
				deadline_n = '0;
				last_cmd_n = '0;
				tail_n     = 2'd0;
				if (item.link_up) kind = KIND_SILENCE;
			end
			MODE_TICK: begin
				if (!item.link_up) begin
					if (link_was_q) begin
						silent_n   = 1'b1;
						active_n   = 1'b0;
						deadline_n = '0;
						last_cmd_n = '0;
						tail_n     = 2'd0;
					end
					link_was_n = 1'b0;
				end else begin
					link_was_n = 1'b1;
					if (active_q) begin
						// command watchdog
						if (!silent_q && last_cmd_q != '0 && wd_expired) begin
							silent_n   = 1'b1;
							tail_n     = TAIL_PACKETS;
							last_cmd_n = '0;
							fired      = 1'b1;
						end
						// packet deadline
						if (due) begin
							kind = KIND_RENDER;
							if (silent_n && tail_n == 2'd0) begin
								active_n   = 1'b0;
								deadline_n = '0;
							end else begin
								if (silent_n) tail_n = tail_n - 2'd1;
								if (late) deadline_n = item.now_us + interval_w;
								else      deadline_n = deadline_q + interval_w;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silent_q   <= 1'b1;
			active_q   <= 1'b0;
			deadline_q <= '0;
			last_cmd_q <= '0;
			tail_q     <= 2'd0;
			link_was_q <= 1'b0;
		end else if (step_en) begin
			silent_q   <= silent_n;
			active_q   <= active_n;
			deadline_q <= deadline_n;
			last_cmd_q <= last_cmd_n;
			tail_q     <= tail_n;
			link_was_q <= link_was_n;
		end
	end

	assign result.packet_kind      = kind;
	assign result.gain_q8          = (kind == KIND_RENDER) ? cfg.gain_q8 : 11'd0;
	assign result.synth_silent_now = silent_n;
	assign result.watchdog_fired   = fired;
	assign result.transport_on     = active_n;

endmodule

@@ sv/haptic_packet_pacer.sv @@
// ----------------------------------------------------------------------------
// haptic_packet_pacer
// Paces haptic packet emission from apply, stop and tick items.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result item. The block takes one item
// per clock while the result side does not stall; an item is latched in an
// input register, evaluated against the pacer state in one pass, and its result
// is then captured in the output register, where it waits until it is taken.
// The output register decouples the sides: input is accepted while a result
// waits, as long as the input register can move on. Configuration writes take
// effect on the next clock and should be made only while no item is in flight.
module haptic_packet_pacer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // rumble_silent, link_up, now_us[47:0], zero pad
	input  logic [1:0]  s_tuser,   // mode
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // gain_q8[10:0], synth_silent_now, watchdog_fired,
	                               // transport_on, zero pad
	output logic [1:0]  m_tuser    // packet_kind
);
	import hpp_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// the input register moves on when the result register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	hpp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hpp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode          <= s_tuser;
			item_s1.rumble_silent <= s_tdata[0];
			item_s1.link_up       <= s_tdata[1];
			item_s1.now_us        <= s_tdata[TIME_W+1:2];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.packet_kind;
	assign m_tdata  = {2'b00, res_s2.transport_on, res_s2.watchdog_fired,
	                   res_s2.synth_silent_now, res_s2.gain_q8};

	// watchdog silence is always visible in the same result
	a_fired_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.watchdog_fired |-> res_s2.synth_silent_now)
		else $error("watchdog fired without silent synth");

	// only rendered packets carry gain
	a_gain_render: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.packet_kind != KIND_RENDER |-> res_s2.gain_q8 == 11'd0)
		else $error("gain on a non-rendered result");

	// an explicit silent packet leaves everything idle
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.packet_kind == KIND_SILENCE
		|-> !res_s2.transport_on && res_s2.synth_silent_now)
		else $error("silent packet with transport still active");

	// input stalls only when both registers hold items
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2)
		else $error("input stalled with a free register");

endmodule

@@ dv/haptic_packet_pacer_checker.sv @@
// ----------------------------------------------------------------------------
// haptic_packet_pacer_checker
// Watches the configuration port and both item channels of the pacer. It keeps
// its own copy of the pacer state, works out the result of every accepted input
// item and compares each accepted result item with the oldest one still owed.
// ----------------------------------------------------------------------------
module haptic_packet_pacer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,   // rumble_silent, link_up, now_us[47:0], zero pad
	input  logic [1:0]  s_tuser,   // mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // gain_q8[10:0], synth_silent_now, watchdog_fired,
	                               // transport_on, zero pad
	input  logic [1:0]  m_tuser,   // packet_kind
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hpp_pkg::*;

	localparam logic [5:0] GAIN_TENTHS_RST = 6'd10;

	// configuration copy
	logic [5:0]        gain_tenths = GAIN_TENTHS_RST;
	logic [15:0]       interval_us = INTERVAL_RST;
	logic [23:0]       timeout_us  = TIMEOUT_RST;

	// pacer state copy
	logic              synth_quiet = 1'b1;
	logic              xport_on    = 1'b0;
	logic [TIME_W-1:0] deadline    = '0;
	logic [TIME_W-1:0] last_cmd    = '0;
	logic [1:0]        tail_cnt    = '0;
	logic              link_prev   = 1'b0;

	result_t owed_results[$];

	// back to the idle state, link history kept
	function automatic void clear_pacer();
		synth_quiet = 1'b1;
		xport_on    = 1'b0;
		deadline    = '0;
		last_cmd    = '0;
		tail_cnt    = '0;
	endfunction

	// advance the state copy by one item and return the result it causes
	function automatic result_t pace_item(item_t it);
		result_t           r;
		logic              go_idle;
		logic [TIME_W-1:0] lag;
		int                g;
		r       = '0;
		go_idle = 1'b0;
		case (it.mode)
			MODE_APPLY: begin
				synth_quiet = it.rumble_silent;
				last_cmd    = it.now_us;
				if (!xport_on)
					deadline = '0;
				xport_on = 1'b1;
				tail_cnt = it.rumble_silent ? TAIL_PACKETS : 2'd0;
			end
			MODE_STOP: begin
				clear_pacer();
				if (it.link_up)
					r.packet_kind = KIND_SILENCE;
			end
			MODE_TICK: begin
				if (!it.link_up) begin
					if (link_prev)
						clear_pacer();
					link_prev = 1'b0;
				end else begin
					link_prev = 1'b1;
					if (xport_on) begin
						// command watchdog
						lag = it.now_us - last_cmd;
						if (!synth_quiet && last_cmd != '0 && lag >= TIME_W'(timeout_us)) begin
							synth_quiet      = 1'b1;
							tail_cnt         = TAIL_PACKETS;
							last_cmd         = '0;
							r.watchdog_fired = 1'b1;
						end
						// deadline reached: render one packet
						if (deadline == '0 || it.now_us >= deadline) begin
							g             = (int'(gain_tenths) * 256 + 5) / 10;
							r.packet_kind = KIND_RENDER;
							r.gain_q8     = g[10:0];
							if (synth_quiet) begin
								if (tail_cnt == 2'd0) begin
									xport_on = 1'b0;
									deadline = '0;
									go_idle  = 1'b1;
								end else begin
									tail_cnt = tail_cnt - 2'd1;
								end
							end
							if (!go_idle) begin
								lag = it.now_us - deadline;
								if (deadline == '0 || lag > TIME_W'(interval_us))
									deadline = it.now_us + TIME_W'(interval_us);
								else
									deadline = deadline + TIME_W'(interval_us);
							end
						end
					end
				end
			end
			default: ;
		endcase
		r.synth_silent_now = synth_quiet;
		r.transport_on     = xport_on;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// config writes, input items into the predictor, result items against it
	always @(posedge clk or negedge arst_n) begin : watch
		item_t   it;
		result_t want;
		result_t got;
		if (!arst_n) begin
			clear_pacer();
			link_prev   = 1'b0;
			gain_tenths = GAIN_TENTHS_RST;
			interval_us = INTERVAL_RST;
			timeout_us  = TIMEOUT_RST;
			owed_results.delete();
			fail_count  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_TENTHS: gain_tenths = cfg_data[5:0];
					REG_INTERVAL:    interval_us = cfg_data[15:0];
					REG_TIMEOUT:     timeout_us  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				it.mode          = s_tuser;
				it.rumble_silent = s_tdata[0];
				it.link_up       = s_tdata[1];
				it.now_us        = s_tdata[49:2];
				owed_results.push_back(pace_item(it));
			end
			if (m_tvalid && m_tready) begin
				got.packet_kind      = m_tuser;
				got.gain_q8          = m_tdata[10:0];
				got.synth_silent_now = m_tdata[11];
				got.watchdog_fired   = m_tdata[12];
				got.transport_on     = m_tdata[13];
				if (owed_results.size() == 0) begin
					$error("result item with no expectation: packet_kind %0d", m_tuser);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("packet_kind", want.packet_kind, got.packet_kind);
					check_field("gain_q8", want.gain_q8, got.gain_q8);
					check_field("synth_silent_now", want.synth_silent_now,
						got.synth_silent_now);
					check_field("watchdog_fired", want.watchdog_fired, got.watchdog_fired);
					check_field("transport_on", want.transport_on, got.transport_on);
				end
			end
		end
		pending = owed_results.size();
	end

endmodule

@@ dv/haptic_packet_pacer_test.sv @@
// ----------------------------------------------------------------------------
// haptic_packet_pacer_test
// Drives apply, stop and tick items into the pacer under a series of register
// settings, with random gaps on the input side and random stalls on the result
// side; the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module haptic_packet_pacer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hpp_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         PHASE_ITEMS = 124;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // rumble_silent, link_up, now_us[47:0], zero pad
	logic [1:0]  s_tuser;   // mode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // gain_q8[10:0], synth_silent_now, watchdog_fired,
	                        // transport_on, zero pad
	logic [1:0]  m_tuser;   // packet_kind
	int          fail_count;
	int          pending;

	// stimulus bookkeeping
	logic [TIME_W-1:0] t_now;
	logic [15:0]       cur_interval = INTERVAL_RST;
	logic [23:0]       cur_timeout  = TIMEOUT_RST;
	int                sent_count   = 0;
	bit                tx_quiet     = 1'b0;
	int                cycles       = 0;

	haptic_packet_pacer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	haptic_packet_pacer_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("haptic_packet_pacer_test: FAIL");
				$finish;
			end
		end
	end

	// result side: random stalls, with quiet stretches
	initial begin : result_side
		int stall_left;
		int quiet_left;
		int p;
		bit rx_quiet;
		stall_left = 0;
		quiet_left = 0;
		rx_quiet   = 1'b0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet_left == 0) begin
				rx_quiet   = ($urandom_range(0, 3) == 0);
				quiet_left = $urandom_range(20, 300);
			end else begin
				quiet_left--;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_quiet) begin
					p = $urandom_range(0, 99);
					if (p >= 90)
						stall_left = $urandom_range(8, 40);
					else if (p >= 60)
						stall_left = $urandom_range(1, 3);
				end
			end
		end
	end

	function automatic int gap_len();
		int p;
		if (tx_quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one item, wait for its handshake, then maybe idle
	task automatic send_item(logic [1:0] mode, logic silent, logic link,
		logic [TIME_W-1:0] now);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, now, link, silent};
		do
			@(posedge clk);
		while (!s_tready);
		if (mode != MODE_UNUSED)
			sent_count++;
		gap = gap_len();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop valid and wait until every owed result has come out
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(logic [5:0] gain, logic [15:0] interval, logic [23:0] tmo);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAIN_TENTHS;
		cfg_data  <= {18'd0, gain};
		@(negedge clk);
		cfg_index <= REG_INTERVAL;
		cfg_data  <= {8'd0, interval};
		@(negedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= tmo;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_interval = interval;
		cur_timeout  = tmo;
	endtask

	// time between ticks: mostly near the interval, sometimes a stall
	function automatic logic [TIME_W-1:0] tick_step();
		int     p;
		longint iv;
		iv = longint'(cur_interval);
		p  = $urandom_range(0, 99);
		if (p < 50)
			return TIME_W'(iv - iv / 8 + longint'($urandom_range(0, cur_interval / 4)));
		if (p < 75)
			return TIME_W'($urandom_range(0, cur_interval));
		if (p < 90)
			return TIME_W'(iv * longint'($urandom_range(2, 6)));
		return TIME_W'($urandom_range(0, cur_timeout));
	endfunction

	task automatic tick_run(int n, int link_down_pct);
		repeat (n) begin
			t_now = t_now + tick_step();
			send_item(MODE_TICK, 1'($urandom), ($urandom_range(0, 99) >= link_down_pct),
				t_now);
		end
	endtask

	// one random sequence, mostly well formed
	task automatic random_sequence();
		int p;
		tx_quiet = ($urandom_range(0, 9) < 2);
		p = $urandom_range(0, 99);
		if ($urandom_range(0, 29) == 0)
			t_now = TIME_MAX - TIME_W'($urandom_range(0, 200000));
		if (p < 38) begin
			// active rumble with ticks
			send_item(MODE_APPLY, 1'b0, 1'($urandom), t_now);
			tick_run($urandom_range(2, 12), 4);
		end else if (p < 56) begin
			// rumble goes silent, trailing packets
			tick_run($urandom_range(0, 2), 0);
			send_item(MODE_APPLY, 1'b1, 1'($urandom), t_now);
			tick_run($urandom_range(1, 5), 0);
		end else if (p < 66) begin
			// watchdog expiry
			send_item(MODE_APPLY, 1'b0, 1'($urandom), t_now);
			tick_run($urandom_range(0, 2), 0);
			t_now = t_now + TIME_W'(cur_timeout) + TIME_W'($urandom_range(0, 3)) - TIME_W'(1);
			send_item(MODE_TICK, 1'($urandom), 1'b1, t_now);
			tick_run($urandom_range(1, 4), 0);
		end else if (p < 74) begin
			// stop, then ticks
			send_item(MODE_STOP, 1'($urandom), 1'($urandom), t_now);
			tick_run($urandom_range(0, 3), 10);
		end else if (p < 84) begin
			// link drops and comes back
			send_item(MODE_APPLY, 1'($urandom), 1'($urandom), t_now);
			tick_run($urandom_range(1, 3), 100);
			tick_run($urandom_range(1, 4), 0);
		end else begin
			// noise: any mode, any field
			if ($urandom_range(0, 3) == 0)
				t_now = TIME_W'({$urandom, $urandom});
			else if ($urandom_range(0, 9) == 0)
				t_now = '0;
			send_item(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), t_now);
		end
	endtask

	task automatic directed_items();
		// link down at time zero, then a command at time zero
		send_item(MODE_TICK, 1'b0, 1'b0, '0);
		send_item(MODE_APPLY, 1'b0, 1'b1, '0);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd5);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd100);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd10005);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd600000);
		// watchdog then trailing packets then idle
		send_item(MODE_APPLY, 1'b0, 1'b0, 48'd1000000);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd1600000);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd1610000);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd1620000);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd1630000);
		// stops with link up and down
		send_item(MODE_APPLY, 1'b1, 1'b1, 48'd2000000);
		send_item(MODE_STOP, 1'b1, 1'b1, 48'd2000001);
		send_item(MODE_STOP, 1'b0, 1'b0, 48'd2000002);
		send_item(MODE_UNUSED, 1'b1, 1'b1, TIME_MAX);
		// deadline wraps to zero at the top of the time range
		send_item(MODE_APPLY, 1'b0, 1'b1, TIME_MAX - 48'd19999);
		send_item(MODE_TICK, 1'b1, 1'b1, TIME_MAX - 48'd19999);
		send_item(MODE_TICK, 1'b1, 1'b1, TIME_MAX - 48'd9999);
		send_item(MODE_TICK, 1'b1, 1'b1, TIME_MAX);
		// link loss clears an active transport
		send_item(MODE_TICK, 1'b1, 1'b0, TIME_MAX);
		send_item(MODE_TICK, 1'b0, 1'b1, 48'd3);
	endtask

	// reset, directed items, then random phases under changing registers
	initial begin : stimulus
		logic [5:0]  gain;
		logic [15:0] interval;
		logic [23:0] tmo;
		int          phase_end;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_APPLY;
		t_now     = 48'd3000000;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_items();

		for (int ph = 0; ph < 9; ph++) begin
			settle();
			case (ph)
				0: begin gain = 6'd50; interval = 16'd1;     tmo = 24'd1;        end
				1: begin gain = 6'd0;  interval = 16'hFFFF;  tmo = 24'hFFFFFF;   end
				2: begin gain = 6'd63; interval = 16'd0;     tmo = 24'd0;        end
				3: begin gain = 6'($urandom); interval = 16'd100; tmo = 24'd1000; end
				4: begin
					gain = 6'($urandom_range(51, 63)); interval = 16'd500; tmo = 24'd3000;
				end
				5: begin gain = 6'($urandom); interval = 16'd2000; tmo = 24'd20000; end
				6: begin gain = 6'd37; interval = 16'd10000; tmo = 24'd500000;  end
				7: begin
					gain = 6'($urandom_range(0, 50)); interval = 16'($urandom_range(1, 300));
					tmo  = 24'($urandom_range(1, 5000));
				end
				default: begin
					gain = 6'($urandom); interval = 16'($urandom); tmo = 24'($urandom);
				end
			endcase
			write_regs(gain, interval, tmo);
			phase_end = sent_count + PHASE_ITEMS;
			while (sent_count < phase_end)
				random_sequence();
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("haptic_packet_pacer_test: PASS");
		else
			$display("haptic_packet_pacer_test: FAIL");
		$finish;
	end

endmodule
